FILE: rtl/u2u_pkg.sv
// shared types and constants for the utf-16le to utf-8 transcoder
// no dependencies; used by u2u_decode, u2u_serial and the top level

package u2u_pkg;

  // status codes carried with every result
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ODD_LEN   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_BAD_PAIR  = 3'd3;
  localparam logic [2:0] ST_LONE_LOW  = 3'd4;

  // surrogate ranges
  localparam logic [15:0] HI_SURR_MIN = 16'hd800;
  localparam logic [15:0] HI_SURR_MAX = 16'hdbff;
  localparam logic [15:0] LO_SURR_MIN = 16'hdc00;
  localparam logic [15:0] LO_SURR_MAX = 16'hdfff;

  // code point limits for 1, 2 and 3 byte forms
  localparam logic [20:0] LIM_ONE   = 21'h00080;
  localparam logic [20:0] LIM_TWO   = 21'h00800;
  localparam logic [20:0] LIM_THREE = 21'h10000;

  // lead and continuation byte marks
  localparam logic [7:0] LEAD_TWO   = 8'hc0;
  localparam logic [7:0] LEAD_THREE = 8'he0;
  localparam logic [7:0] LEAD_FOUR  = 8'hf0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  // up to four result bytes produced by one input byte
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // number of results minus one
    logic            bvalid;
    logic [2:0]      status;
    logic            str_last;  // final result closes the string
  } group_t;

endpackage

FILE: rtl/u2u_decode.sv
// pairs bytes into code units, tracks surrogates and errors, builds a result group
// depends on u2u_pkg

module u2u_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_v,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            grp_free,
  output logic            take,
  output logic            grp_load,
  output u2u_pkg::group_t grp
);

  logic [7:0] held_low_byte, held_low_byte_next;
  logic       have_low_byte, have_low_byte_next;
  logic [9:0] hs_bits, hs_bits_next;
  logic       have_hs, have_hs_next;
  logic [2:0] error_code, error_code_next;
  logic       in_error, in_error_next;

  logic        has_res;
  logic [15:0] unit;
  logic [20:0] supp_cp;

  function automatic u2u_pkg::group_t encode(input logic [20:0] cp);
    u2u_pkg::group_t g;
    g = '0;
    g.bvalid = 1'b1;
    g.status = u2u_pkg::ST_OK;
    if (cp < u2u_pkg::LIM_ONE) begin
      g.bytes[0] = cp[7:0];
      g.last_idx = 2'd0;
    end else if (cp < u2u_pkg::LIM_TWO) begin
      g.bytes[0] = u2u_pkg::LEAD_TWO | {3'b000, cp[10:6]};
      g.bytes[1] = u2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
      g.last_idx = 2'd1;
    end else if (cp < u2u_pkg::LIM_THREE) begin
      g.bytes[0] = u2u_pkg::LEAD_THREE | {4'b0000, cp[15:12]};
      g.bytes[1] = u2u_pkg::CONT_MARK | {2'b00, cp[11:6]};
      g.bytes[2] = u2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
      g.last_idx = 2'd2;
    end else begin
      g.bytes[0] = u2u_pkg::LEAD_FOUR | {5'b00000, cp[20:18]};
      g.bytes[1] = u2u_pkg::CONT_MARK | {2'b00, cp[17:12]};
      g.bytes[2] = u2u_pkg::CONT_MARK | {2'b00, cp[11:6]};
      g.bytes[3] = u2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
      g.last_idx = 2'd3;
    end
    return g;
  endfunction

  assign unit    = {in_byte, held_low_byte};
  assign supp_cp = 21'h10000 + {1'b0, hs_bits, unit[9:0]};

  always_comb begin
    held_low_byte_next = held_low_byte;
    have_low_byte_next = have_low_byte;
    hs_bits_next       = hs_bits;
    have_hs_next       = have_hs;
    error_code_next    = error_code;
    in_error_next      = in_error;
    has_res            = 1'b0;
    grp                = '0;

    if (in_error) begin
      if (in_last) begin
        has_res    = 1'b1;
        grp.status = error_code;
      end
    end else if (!have_low_byte) begin
      if (in_last) begin
        has_res    = 1'b1;
        grp.status = u2u_pkg::ST_ODD_LEN;
      end else begin
        held_low_byte_next = in_byte;
        have_low_byte_next = 1'b1;
      end
    end else begin
      held_low_byte_next = '0;
      have_low_byte_next = 1'b0;
      if (have_hs) begin
        if (unit inside {[u2u_pkg::LO_SURR_MIN : u2u_pkg::LO_SURR_MAX]}) begin
          has_res      = 1'b1;
          grp          = encode(supp_cp);
          hs_bits_next = '0;
          have_hs_next = 1'b0;
        end else begin
          has_res    = 1'b1;
          grp.status = u2u_pkg::ST_BAD_PAIR;
        end
      end else if (unit inside {[u2u_pkg::HI_SURR_MIN : u2u_pkg::HI_SURR_MAX]}) begin
        if (in_last) begin
          has_res    = 1'b1;
          grp.status = u2u_pkg::ST_TRUNC;
        end else begin
          hs_bits_next = unit[9:0];
          have_hs_next = 1'b1;
        end
      end else if (unit inside {[u2u_pkg::LO_SURR_MIN : u2u_pkg::LO_SURR_MAX]}) begin
        has_res    = 1'b1;
        grp.status = u2u_pkg::ST_LONE_LOW;
      end else begin
        has_res = 1'b1;
        grp     = encode({5'b00000, unit});
      end
    end

    // a fresh error drops any pending unit and waits for the final byte
    if (!in_error && has_res && !grp.bvalid) begin
      held_low_byte_next = '0;
      have_low_byte_next = 1'b0;
      hs_bits_next       = '0;
      have_hs_next       = 1'b0;
      error_code_next    = grp.status;
      in_error_next      = 1'b1;
    end

    // the final byte always leaves the state as after reset
    if (in_last) begin
      held_low_byte_next = '0;
      have_low_byte_next = 1'b0;
      hs_bits_next       = '0;
      have_hs_next       = 1'b0;
      error_code_next    = u2u_pkg::ST_OK;
      in_error_next      = 1'b0;
    end

    grp.str_last = in_last;
  end

  // a byte with no result never waits for the serializer
  assign take     = in_v && (grp_free || !has_res);
  assign grp_load = take && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_low_byte <= '0;
      have_low_byte <= 1'b0;
      hs_bits       <= '0;
      have_hs       <= 1'b0;
      error_code    <= u2u_pkg::ST_OK;
      in_error      <= 1'b0;
    end else if (take) begin
      held_low_byte <= held_low_byte_next;
      have_low_byte <= have_low_byte_next;
      hs_bits       <= hs_bits_next;
      have_hs       <= have_hs_next;
      error_code    <= error_code_next;
      in_error      <= in_error_next;
    end
  end

endmodule

FILE: rtl/u2u_serial.sv
// result register: holds one group and hands its bytes out one per transaction
// depends on u2u_pkg

module u2u_serial (
  input  logic            clk,
  input  logic            rst,
  input  logic            grp_load,
  input  u2u_pkg::group_t grp_in,
  output logic            grp_free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic [2:0]      status,
  output logic            run_end,
  output logic            string_end
);

  u2u_pkg::group_t grp;
  logic            grp_v;
  logic [1:0]      idx;
  logic            out_acc;
  logic            is_final;

  assign is_final = (idx == grp.last_idx);
  assign out_acc  = grp_v && !out_stall;
  assign grp_free = !grp_v || (out_acc && is_final);

  assign out_valid  = grp_v;
  assign out_byte   = grp.bytes[idx];
  assign byte_valid = grp.bvalid;
  assign status     = grp.status;
  assign run_end    = is_final;
  assign string_end = is_final && grp.str_last;

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_v <= 1'b0;
      idx   <= '0;
    end else if (grp_load) begin
      grp_v <= 1'b1;
      idx   <= '0;
    end else if (out_acc && is_final) begin
      grp_v <= 1'b0;
      idx   <= '0;
    end else if (out_acc) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

FILE: rtl/utf16le_to_utf8_transcoder.sv
// top level of the utf-16le to utf-8 transcoder: input register, decoder, serializer
// depends on u2u_pkg, u2u_decode and u2u_serial
//
//   channel  handshake            payload
//   input    in_valid/in_stall    data_byte, last_byte
//   output   out_valid/out_stall  out_byte, byte_valid, status, run_end, string_end
//
// an input byte is held in the input register, then decodes into the result
// register, from which its first result is offered; it waits in the input register
// while the result register is still busy with the previous group
// the result register gives one output byte per cycle while out_stall is low; bytes
// that give no result pass at one per cycle
// a new byte is taken in the cycle the last byte of the previous group leaves
// synchronous reset clears the string state and both valid flags
// out_stall holds the current result and backs up into in_stall

module utf16le_to_utf8_transcoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [2:0] status,
  output logic       run_end,
  output logic       string_end
);

  logic            in_v;
  logic [7:0]      in_byte;
  logic            in_last;
  logic            take;
  logic            grp_load;
  logic            grp_free;
  u2u_pkg::group_t grp;

  assign in_stall = in_v && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!in_stall) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  u2u_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_v     (in_v),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .grp_free (grp_free),
    .take     (take),
    .grp_load (grp_load),
    .grp      (grp)
  );

  u2u_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .grp_load   (grp_load),
    .grp_in     (grp),
    .grp_free   (grp_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule

FILE: bench/tb.sv
// self-checking bench for utf16le_to_utf8_transcoder: directed and random strings
// predicts the utf-8 byte stream per accepted input transaction and checks each result
// depends on u2u_pkg and the transcoder rtl

module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic [2:0] stat;
    logic       run_last;
    logic       str_last;
  } utf8_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] status;
  logic       run_end;
  logic       string_end;

  // predictor copy of the string state
  logic [7:0] held_lo;
  logic       have_lo;
  logic [9:0] hi_bits;
  logic       have_hi;
  logic [2:0] err_code;
  logic       in_err;

  utf8_result_t utf8_out_q[$];
  logic [7:0]   str_bytes[$];
  utf8_result_t want;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  utf16le_to_utf8_transcoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .run_end    (run_end),
    .string_end (string_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic utf8_result_t make_result(input logic [7:0] b, input logic bv,
                                               input logic [2:0] st);
    utf8_result_t r;
    r = '0;
    r.data = b;
    r.bvalid = bv;
    r.stat = st;
    return r;
  endfunction

  function void clear_string_state();
    held_lo = '0;
    have_lo = 1'b0;
    hi_bits = '0;
    have_hi = 1'b0;
    err_code = u2u_pkg::ST_OK;
    in_err = 1'b0;
  endfunction

  // expected utf-8 results of one accepted input byte
  function void transcode_byte(input logic [7:0] b, input logic l);
    utf8_result_t res [4];
    int           n;
    logic [15:0]  unit;
    logic [20:0]  cp;
    logic         have_cp;
    logic [2:0]   err;
    n = 0;
    have_cp = 1'b0;
    cp = '0;
    err = u2u_pkg::ST_OK;
    for (int k = 0; k < 4; k++) res[k] = '0;
    if (in_err) begin
      if (l) begin
        res[0] = make_result(8'h00, 1'b0, err_code);
        n = 1;
      end
    end else if (!have_lo) begin
      if (l) begin
        err = u2u_pkg::ST_ODD_LEN;
      end else begin
        held_lo = b;
        have_lo = 1'b1;
      end
    end else begin
      unit = {b, held_lo};
      held_lo = '0;
      have_lo = 1'b0;
      if (have_hi) begin
        if (unit >= u2u_pkg::LO_SURR_MIN && unit <= u2u_pkg::LO_SURR_MAX) begin
          cp = 21'h10000 + {1'b0, hi_bits, 10'd0} + {11'd0, unit[9:0]};
          have_cp = 1'b1;
        end else begin
          err = u2u_pkg::ST_BAD_PAIR;
        end
        hi_bits = '0;
        have_hi = 1'b0;
      end else if (unit >= u2u_pkg::HI_SURR_MIN && unit <= u2u_pkg::HI_SURR_MAX) begin
        if (l) begin
          err = u2u_pkg::ST_TRUNC;
        end else begin
          hi_bits = unit[9:0];
          have_hi = 1'b1;
        end
      end else if (unit >= u2u_pkg::LO_SURR_MIN && unit <= u2u_pkg::LO_SURR_MAX) begin
        err = u2u_pkg::ST_LONE_LOW;
      end else begin
        cp = {5'd0, unit};
        have_cp = 1'b1;
      end
    end
    if (err != u2u_pkg::ST_OK) begin
      res[0] = make_result(8'h00, 1'b0, err);
      n = 1;
      in_err = 1'b1;
      err_code = err;
    end
    if (have_cp) begin
      if (cp < u2u_pkg::LIM_ONE) begin
        res[0] = make_result(cp[7:0], 1'b1, u2u_pkg::ST_OK);
        n = 1;
      end else if (cp < u2u_pkg::LIM_TWO) begin
        res[0] = make_result(u2u_pkg::LEAD_TWO | {3'd0, cp[10:6]}, 1'b1, u2u_pkg::ST_OK);
        res[1] = make_result(u2u_pkg::CONT_MARK | {2'd0, cp[5:0]}, 1'b1, u2u_pkg::ST_OK);
        n = 2;
      end else if (cp < u2u_pkg::LIM_THREE) begin
        res[0] = make_result(u2u_pkg::LEAD_THREE | {4'd0, cp[15:12]}, 1'b1,
                             u2u_pkg::ST_OK);
        res[1] = make_result(u2u_pkg::CONT_MARK | {2'd0, cp[11:6]}, 1'b1, u2u_pkg::ST_OK);
        res[2] = make_result(u2u_pkg::CONT_MARK | {2'd0, cp[5:0]}, 1'b1, u2u_pkg::ST_OK);
        n = 3;
      end else begin
        res[0] = make_result(u2u_pkg::LEAD_FOUR | {5'd0, cp[20:18]}, 1'b1,
                             u2u_pkg::ST_OK);
        res[1] = make_result(u2u_pkg::CONT_MARK | {2'd0, cp[17:12]}, 1'b1,
                             u2u_pkg::ST_OK);
        res[2] = make_result(u2u_pkg::CONT_MARK | {2'd0, cp[11:6]}, 1'b1, u2u_pkg::ST_OK);
        res[3] = make_result(u2u_pkg::CONT_MARK | {2'd0, cp[5:0]}, 1'b1, u2u_pkg::ST_OK);
        n = 4;
      end
    end
    if (l) clear_string_state();
    if (n > 0) begin
      res[n-1].run_last = 1'b1;
      res[n-1].str_last = l;
    end
    for (int k = 0; k < n; k++) utf8_out_q.push_back(res[k]);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (utf8_out_q.size() == 0) begin
        $error("result with nothing expected: out_byte %0h status %0d", out_byte, status);
        mismatch_count++;
      end else begin
        want = utf8_out_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          mismatch_count++;
        end
        if (byte_valid !== want.bvalid) begin
          $error("byte_valid: expected %0b, got %0b", want.bvalid, byte_valid);
          mismatch_count++;
        end
        if (status !== want.stat) begin
          $error("status: expected %0d, got %0d", want.stat, status);
          mismatch_count++;
        end
        if (run_end !== want.run_last) begin
          $error("run_end: expected %0b, got %0b", want.run_last, run_end);
          mismatch_count++;
        end
        if (string_end !== want.str_last) begin
          $error("string_end: expected %0b, got %0b", want.str_last, string_end);
          mismatch_count++;
        end
      end
    end
  end

  // one input transaction, with a random gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    transcode_byte(b, l);
  endtask

  task automatic add_unit(input logic [15:0] u);
    str_bytes.push_back(u[7:0]);
    str_bytes.push_back(u[15:8]);
  endtask

  task automatic send_string();
    for (int k = 0; k < str_bytes.size(); k++)
      send_byte(str_bytes[k], k == str_bytes.size() - 1);
    str_bytes.delete();
  endtask

  // sender holds off until every expected result is out
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (utf8_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_code_point_forms();
    // one, two and three byte forms with all-zero and all-one payload bits
    add_unit(16'h0000);
    add_unit(16'h07ff);
    add_unit(16'hffff);
    send_string();
    // highest code point through a surrogate pair
    add_unit(16'hdbff);
    add_unit(16'hdfff);
    send_string();
  endtask

  task automatic test_malformed_strings();
    // odd length on a lone byte
    str_bytes.push_back(8'h41);
    send_string();
    // high surrogate ends the string
    add_unit(16'hd800);
    send_string();
    // bad pair mid-string, the rest is dropped up to the end marker
    add_unit(16'hd800);
    add_unit(16'h0041);
    add_unit(16'h1234);
    send_string();
    // lone low surrogate on the final byte
    add_unit(16'hdc00);
    send_string();
    // odd length while a high surrogate is pending
    add_unit(16'hd9a5);
    str_bytes.push_back(8'hff);
    send_string();
    wait_all_results();
  endtask

  task automatic add_good_unit();
    logic [9:0] hi;
    logic [9:0] lo;
    hi = 10'($urandom_range(1023));
    lo = 10'($urandom_range(1023));
    case ($urandom_range(9))
      0, 1, 2, 3: add_unit(16'($urandom_range(16'h007f)));
      4, 5:       add_unit(16'($urandom_range(16'h07ff, 16'h0080)));
      6:          add_unit(16'($urandom_range(16'hd7ff, 16'h0800)));
      7:          add_unit(16'($urandom_range(16'hffff, 16'he000)));
      default: begin
        add_unit(u2u_pkg::HI_SURR_MIN | {6'd0, hi});
        add_unit(u2u_pkg::LO_SURR_MIN | {6'd0, lo});
      end
    endcase
  endtask

  task automatic test_random_strings(input int send_pct, input int recv_pct, input int n_bytes);
    int sent;
    int n_units;
    int n_tail;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_bytes) begin
      n_units = $urandom_range(6, 1);
      for (int k = 0; k < n_units; k++) add_good_unit();
      if ($urandom_range(99) < 20) begin
        n_tail = $urandom_range(3);
        case ($urandom_range(4))
          0: str_bytes.push_back(8'($urandom_range(255)));
          1: add_unit(16'($urandom_range(u2u_pkg::HI_SURR_MAX, u2u_pkg::HI_SURR_MIN)));
          2: begin
            add_unit(16'($urandom_range(u2u_pkg::LO_SURR_MAX, u2u_pkg::LO_SURR_MIN)));
            for (int k = 0; k < n_tail; k++) add_good_unit();
          end
          3: begin
            add_unit(16'($urandom_range(u2u_pkg::HI_SURR_MAX, u2u_pkg::HI_SURR_MIN)));
            if ($urandom_range(1))
              add_unit(16'($urandom_range(u2u_pkg::HI_SURR_MAX, u2u_pkg::HI_SURR_MIN)));
            else add_unit(16'($urandom_range(16'hd7ff)));
            for (int k = 0; k < n_tail; k++) add_good_unit();
          end
          default: begin
            // raw noise bytes, an odd count from one to seven
            for (int k = 0; k <= n_tail * 2; k++) str_bytes.push_back(8'($urandom_range(255)));
          end
        endcase
      end
      sent += str_bytes.size();
      send_string();
    end
    wait_all_results();
  endtask

  initial begin
    clear_string_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 50;
    test_code_point_forms();
    test_malformed_strings();
    test_random_strings(30, 50, 150);
    test_random_strings(50, 30, 150);
    test_random_strings(0, 0, 130);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
